### rtl/deq_pkg.sv
// Shared constants, request and status codes, and the control/status structs
// of the double-ended priority queue. No dependencies; every other file depends on it.
package deq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DEL_MAX = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_MIN = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REPORT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        RD_PTR_M1,
        RD_PTR,
        RD_CNT_M1,
        RD_ZERO
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_SHIFT,
        WR_PLACE,
        WR_DMIN
    } wr_sel_t;

    typedef struct packed {
        logic    accept;
        logic    ptr_ld_cnt;
        logic    ptr_ld_one;
        logic    ptr_dec;
        logic    ptr_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cap_max;
        logic    cap_min;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             cnt_zero;
        logic             cnt_full;
        logic             ptr_zero;
        logic             ptr_end;
        logic             v_less;
        logic             out_free;
    } sts_t;

endpackage

### rtl/deq_req_if.sv
// Request channel: valid/ready handshake carrying one queue request.
// Depends on deq_pkg for field widths.
interface deq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic        [deq_pkg::REQ_W-1:0]       req_type;
    logic signed [deq_pkg::DATA_W-1:0]      value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

### rtl/deq_res_if.sv
// Result channel: valid/ready handshake carrying one queue result.
// Depends on deq_pkg for field widths.
interface deq_res_if;
    logic                                   valid;
    logic                                   ready;
    logic        [deq_pkg::STAT_W-1:0]      status;
    logic                                   is_empty;
    logic signed [deq_pkg::DATA_W-1:0]      max_value;
    logic signed [deq_pkg::DATA_W-1:0]      min_value;
    logic        [deq_pkg::CNT_W-1:0]       count;

    modport source (output valid, output status, output is_empty, output max_value,
                    output min_value, output count, input ready);
    modport sink   (input valid, input status, input is_empty, input max_value,
                    input min_value, input count, output ready);
endinterface

### rtl/deq_ctrl.sv
// Sequencing state machine of the priority queue: walks insert and
// delete-minimum shifts and the max/min read-back. Depends on deq_pkg.
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  deq_pkg::sts_t sts,
    output deq_pkg::cmd_t cmd
);
    import deq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DISPATCH = 10'b00_0000_0010,
        S_INS_RD   = 10'b00_0000_0100,
        S_INS_CMP  = 10'b00_0000_1000,
        S_DMIN_RD  = 10'b00_0001_0000,
        S_DMIN_WR  = 10'b00_0010_0000,
        S_FIN      = 10'b00_0100_0000,
        S_RMAX     = 10'b00_1000_0000,
        S_RMIN     = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ZERO;
        cmd.wr_sel = WR_PLACE;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FIN;
                case (sts.req)
                    REQ_INSERT:
                    begin
                        if (!sts.cnt_full)
                        begin
                            cmd.ptr_ld_cnt = 1'b1;
                            state_next     = S_INS_RD;
                        end
                    end
                    REQ_DEL_MAX:
                    begin
                        cmd.cnt_dec = !sts.cnt_zero;
                    end
                    REQ_DEL_MIN:
                    begin
                        if (!sts.cnt_zero)
                        begin
                            cmd.ptr_ld_one = 1'b1;
                            state_next     = S_DMIN_RD;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = WR_PLACE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR_M1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (sts.v_less)
                begin
                    cmd.wr_sel  = WR_SHIFT;
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_INS_RD;
                end
                else
                begin
                    cmd.wr_sel  = WR_PLACE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_DMIN_RD:
            begin
                if (sts.ptr_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PTR;
                    state_next = S_DMIN_WR;
                end
            end
            S_DMIN_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_DMIN;
                cmd.ptr_inc = 1'b1;
                state_next  = S_DMIN_RD;
            end
            S_FIN:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CNT_M1;
                    state_next = S_RMAX;
                end
            end
            S_RMAX:
            begin
                // Read data now holds the top entry; fetch the bottom one.
                cmd.cap_max = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_ZERO;
                state_next  = S_RMIN;
            end
            S_RMIN:
            begin
                cmd.cap_min = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shifting and read-back never overlap a write with a new transfer.
    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !cmd.wr_en && !cmd.rd_en && !cmd.load_out)
        else $error("request taken while a request is in progress");

    a_ins_ends: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |=> state_reg == S_FIN)
        else $error("insert did not close into read-back");

    a_load_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == S_IDLE)
        else $error("result loaded without returning to idle");

endmodule

### rtl/deq_dp.sv
// Datapath of the priority queue: sorted store memory, count and walk
// pointer, compare, and the result register. Depends on deq_pkg, deq_res_if.
module deq_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  deq_pkg::cmd_t                       cmd,
    input  logic        [deq_pkg::REQ_W-1:0]    req_type,
    input  logic signed [deq_pkg::DATA_W-1:0]   value,
    output deq_pkg::sts_t                       sts,
    deq_res_if.source                           res
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] store_mem [CAPACITY];

    logic        [CNT_W-1:0]  count_reg;
    logic        [CNT_W-1:0]  count_next;
    logic        [CNT_W-1:0]  ptr_reg;
    logic        [CNT_W-1:0]  ptr_next;
    logic        [REQ_W-1:0]  req_reg;
    logic        [STAT_W-1:0] status_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic                     out_valid_reg;
    logic        [STAT_W-1:0] out_status_reg;
    logic                     out_empty_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic signed [DATA_W-1:0] out_min_reg;
    logic        [CNT_W-1:0]  out_count_reg;

    logic        [CNT_W-1:0]  ptr_m1;
    logic        [CNT_W-1:0]  cnt_m1;
    logic        [IDX_W-1:0]  rd_addr;
    logic        [IDX_W-1:0]  wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic        [STAT_W-1:0] status_new;
    logic                     out_free;

    assign ptr_m1   = ptr_reg - CNT_W'(1);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PTR_M1: rd_addr = ptr_m1[IDX_W-1:0];
            RD_PTR:    rd_addr = ptr_reg[IDX_W-1:0];
            RD_CNT_M1: rd_addr = cnt_m1[IDX_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_SHIFT:
            begin
                wr_addr = ptr_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
            end
            WR_DMIN:
            begin
                wr_addr = ptr_m1[IDX_W-1:0];
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = ptr_reg[IDX_W-1:0];
                wr_data = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        status_new = ST_DONE;
        if (req_type == REQ_INSERT && count_reg == CAP_CNT)
        begin
            status_new = ST_FULL;
        end
        else if ((req_type == REQ_DEL_MAX || req_type == REQ_DEL_MIN) && count_reg == '0)
        begin
            status_new = ST_EMPTY;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_clr)
        begin
            count_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = cnt_m1;
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_ld_cnt)
        begin
            ptr_next = count_reg;
        end
        else if (cmd.ptr_ld_one)
        begin
            ptr_next = CNT_W'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_m1;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            req_reg       <= REQ_REPORT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.accept)
            begin
                req_reg <= req_type;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg  <= value;
            status_reg <= status_new;
        end
        if (cmd.cap_max)
        begin
            max_reg <= rd_data_reg;
        end
        if (cmd.cap_min)
        begin
            min_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= status_reg;
            out_empty_reg  <= (count_reg == '0);
            out_max_reg    <= (count_reg == '0) ? '0 : max_reg;
            out_min_reg    <= (count_reg == '0) ? '0 : min_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign sts.req      = req_reg;
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.cnt_full = (count_reg == CAP_CNT);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.ptr_end  = (ptr_reg >= count_reg);
    assign sts.v_less   = (value_reg < rd_data_reg);
    assign sts.out_free = out_free;

    assign res.valid     = out_valid_reg;
    assign res.status    = out_status_reg;
    assign res.is_empty  = out_empty_reg;
    assign res.max_value = out_max_reg;
    assign res.min_value = out_min_reg;
    assign res.count     = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("held count beyond capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result register overwritten before transfer");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> count_reg < CAP_CNT)
        else $error("insert committed into a full store");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_FULL |-> out_count_reg == CAP_CNT)
        else $error("full status reported below capacity");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_empty_reg == (out_count_reg == '0))
        else $error("empty flag disagrees with count");

endmodule

### rtl/double_ended_priority_queue.sv
// Double-ended priority queue over signed 32-bit values, up to CAPACITY held.
// Depends on deq_pkg, deq_req_if, deq_res_if, deq_ctrl and deq_dp.
// Usage: req (sink) takes one transfer per request; req_type selects insert,
//   delete maximum, delete minimum, report or clear (codes 5 to 7 act as report),
//   value is the insert operand. res (source) gives exactly one transfer per
//   request: status, empty flag, largest and smallest values (0 when empty) and
//   count, all as they stand after the request.
// Timing: one request in work at a time; req.ready is high only when idle. The
//   store is a single-port memory, so every shift of an entry takes a read and
//   then a write. Insert shifts each entry larger than the value up one place;
//   delete minimum shifts every remaining entry down one place. Unless the queue
//   is empty afterwards, the top and bottom entries are then read back before
//   the result is loaded. The next request is taken in the cycle after the
//   result is loaded.
// Reset: clear the count and all control; the store is not cleared, as only
//   entries below the count are ever read. Ready as soon as reset is released.
// Stall: hold a finished result in the output register; the block goes idle, takes
//   the next request and holds its result until res.ready drains the register.
module double_ended_priority_queue (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_res_if.source res
);
    import deq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: owns the request handshake and drives the datapath.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: store, count, pointer, compare and result register.
    deq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_type (req.req_type),
        .value    (req.value),
        .sts      (sts),
        .res      (res)
    );

endmodule
